[src/arx_pkg.sv]
package arx_pkg;

  localparam int COEF_W     = 16;
  localparam int FRAC_SHIFT = 14;
  localparam int DELAY_W    = 4;
  localparam int CFG_IDX_W  = 3;

  // Only this many coefficients of each kind have a register behind them.
  localparam int NUM_A_REGS = 3;
  localparam int NUM_B_REGS = 3;

  localparam int A_ORDER_DEF      = 3;
  localparam int B_ORDER_DEF      = 3;
  localparam int MAX_DELAY_DEF    = 8;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A1    = 3'd0,
    REG_A2    = 3'd1,
    REG_A3    = 3'd2,
    REG_B0    = 3'd3,
    REG_B1    = 3'd4,
    REG_B2    = 3'd5,
    REG_DELAY = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;
  } cfg_wr_t;

endpackage

[src/arx_if.sv]
interface arx_in_if #(
  parameter int SW = arx_pkg::SAMPLE_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] drive_sample;
  logic signed [SW-1:0] noise_sample;

  modport source(output valid, output drive_sample, output noise_sample, input ready);
  modport sink(input valid, input drive_sample, input noise_sample, output ready);
endinterface

interface arx_out_if #(
  parameter int SW = arx_pkg::SAMPLE_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] model_output;
  logic                 saturated;

  modport source(output valid, output model_output, output saturated, input ready);
  modport sink(input valid, input model_output, input saturated, output ready);
endinterface

interface arx_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [arx_pkg::CFG_IDX_W-1:0]  index;
  logic [arx_pkg::COEF_W-1:0]     data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

[src/arx_model_step.sv]
// ARX model stepper. Each accepted word carries a drive sample and a noise sample (Q3.12)
// and yields one word with the new output y = -(a1*y1 + a2*y2 + a3*y3) + (b0*u[n-k] +
// b1*u[n-k-1] + b2*u[n-k-2]) + noise, rounded to Q3.12 and saturated, with a flag when
// clipped. Coefficients are Q1.14 and are written through the configuration channel
// (index 0..2 for a1..a3, 3..5 for b0..b2, 6 for the transport delay k, which is clamped
// to MAX_DELAY); history is cleared only by reset. The block takes one sample per clock
// while its result is taken: the result appears in the output register the cycle after
// acceptance, and the next sample may enter in that same cycle. The output feedback path,
// through the coefficient cells' multipliers, the accumulator adder, rounding and saturation,
// is combinational and sets the clock period. Configuration writes are always ready.
module arx_model_step #(
  parameter int A_ORDER      = arx_pkg::A_ORDER_DEF,
  parameter int B_ORDER      = arx_pkg::B_ORDER_DEF,
  parameter int MAX_DELAY    = arx_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_WIDTH = arx_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  arx_in_if.sink     drive_i,
  arx_out_if.source  result_o,
  arx_cfg_if.sink    cfg_i
);

  localparam int SW       = SAMPLE_WIDTH;
  localparam int PW       = SW + arx_pkg::COEF_W;
  localparam int IN_DEPTH = MAX_DELAY + B_ORDER;
  localparam int NCELL    = (IN_DEPTH > 1) ? IN_DEPTH - 1 : 1;
  localparam int TAP_W    = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam int SEL_W    = $clog2(IN_DEPTH + 16);
  localparam int ACC_W    = PW + $clog2(A_ORDER + B_ORDER + 1) + 1;

  arx_pkg::cfg_wr_t            cfg_wr;
  logic                        in_acc;
  logic                        stage_ready;
  logic [arx_pkg::DELAY_W-1:0] delay_q, delay_d;
  logic [SEL_W-1:0]            delay_ext;
  logic [SEL_W-1:0]            k_sel;

  logic signed [SW-1:0]  in_hist [NCELL];
  logic signed [SW-1:0]  out_hist [A_ORDER];
  logic signed [SW-1:0]  taps [IN_DEPTH];
  logic signed [SW-1:0]  b_tap [B_ORDER];
  logic signed [PW-1:0]  prod_a [A_ORDER];
  logic signed [PW-1:0]  prod_b [B_ORDER];
  logic signed [ACC_W-1:0] acc;
  logic signed [SW-1:0]  y_new;

  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.valid = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  assign drive_i.ready = stage_ready;
  assign in_acc        = drive_i.valid && stage_ready;

  // Transport delay register; indexes 0..5 belong to the coefficient cells.
  assign delay_d = (cfg_i.valid && (cfg_i.index == arx_pkg::REG_DELAY))
                   ? cfg_i.data[arx_pkg::DELAY_W-1:0] : delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= arx_pkg::DELAY_RESET;
    end else begin
      delay_q <= delay_d;
    end
  end

  assign delay_ext = SEL_W'(delay_q);
  assign k_sel     = (delay_ext > SEL_W'(MAX_DELAY)) ? SEL_W'(MAX_DELAY) : delay_ext;

  // Input history: a shift line of cells, newest first.
  for (genvar j = 0; j < NCELL; j++) begin : g_in_cell
    logic signed [SW-1:0] cell_d;
    if (j == 0) begin : g_head
      assign cell_d = drive_i.drive_sample;
    end else begin : g_link
      assign cell_d = in_hist[j-1];
    end
    arx_hist_cell #(.SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .d_i     (cell_d),
      .q_o     (in_hist[j])
    );
  end

  // Tap zero is the sample now entering; older taps come from the cells.
  assign taps[0] = drive_i.drive_sample;
  for (genvar j = 1; j < IN_DEPTH; j++) begin : g_tap
    assign taps[j] = in_hist[j-1];
  end

  // Output history cells hold the saturated outputs, newest first.
  for (genvar i = 0; i < A_ORDER; i++) begin : g_out_cell
    logic signed [SW-1:0] cell_d;
    if (i == 0) begin : g_head
      assign cell_d = y_new;
    end else begin : g_link
      assign cell_d = out_hist[i-1];
    end
    arx_hist_cell #(.SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .d_i     (cell_d),
      .q_o     (out_hist[i])
    );

    arx_coef_cell #(
      .SW       (SW),
      .REG_IDX  (int'(arx_pkg::REG_A1) + i),
      .WRITABLE (i < arx_pkg::NUM_A_REGS)
    ) u_coef (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cfg_i    (cfg_wr),
      .sample_i (out_hist[i]),
      .prod_o   (prod_a[i])
    );
  end

  for (genvar i = 0; i < B_ORDER; i++) begin : g_b_cell
    logic [SEL_W-1:0] sel;
    assign sel      = k_sel + SEL_W'(i);
    assign b_tap[i] = taps[sel[TAP_W-1:0]];

    arx_coef_cell #(
      .SW       (SW),
      .REG_IDX  (int'(arx_pkg::REG_B0) + i),
      .WRITABLE (i < arx_pkg::NUM_B_REGS)
    ) u_coef (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cfg_i    (cfg_wr),
      .sample_i (b_tap[i]),
      .prod_o   (prod_b[i])
    );
  end

  always_comb begin
    acc = ACC_W'(drive_i.noise_sample) <<< arx_pkg::FRAC_SHIFT;
    for (int i = 0; i < A_ORDER; i++) begin
      acc = acc - ACC_W'(prod_a[i]);
    end
    for (int i = 0; i < B_ORDER; i++) begin
      acc = acc + ACC_W'(prod_b[i]);
    end
  end

  arx_out_stage #(
    .SW    (SW),
    .ACC_W (ACC_W)
  ) u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .load_i   (in_acc),
    .ready_o  (stage_ready),
    .y_o      (y_new),
    .result_o (result_o)
  );

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> result_o.valid)
    else $error("accepted sample did not produce a result word");

  a_sat_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.saturated) |->
      (result_o.model_output == {1'b0, {(SW-1){1'b1}}}) ||
      (result_o.model_output == {1'b1, {(SW-1){1'b0}}}))
    else $error("saturation flagged but output is not at a rail");

  a_feedback_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (out_hist[0] == result_o.model_output))
    else $error("newest output history differs from delivered output");

  a_input_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (in_hist[0] == $past(drive_i.drive_sample)))
    else $error("input history did not capture accepted drive sample");

  a_delay_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && (cfg_i.index == arx_pkg::REG_DELAY)) |=>
      (delay_q == $past(cfg_i.data[arx_pkg::DELAY_W-1:0])))
    else $error("transport delay write was lost");
`endif

endmodule

[src/arx_hist_cell.sv]
module arx_hist_cell #(
  parameter int SW = arx_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic signed [SW-1:0] d_i,
  output logic signed [SW-1:0] q_o
);

  logic signed [SW-1:0] sample_q;
  logic signed [SW-1:0] sample_d;

  assign sample_d = shift_i ? d_i : sample_q;
  assign q_o      = sample_q;

  // History is part of the model state, so it is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

endmodule

[src/arx_coef_cell.sv]
module arx_coef_cell #(
  parameter int SW        = arx_pkg::SAMPLE_WIDTH_DEF,
  parameter int REG_IDX   = 0,
  parameter bit WRITABLE  = 1'b1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  arx_pkg::cfg_wr_t                      cfg_i,
  input  logic signed [SW-1:0]                  sample_i,
  output logic signed [SW+arx_pkg::COEF_W-1:0]  prod_o
);

  localparam int PW = SW + arx_pkg::COEF_W;

  logic signed [arx_pkg::COEF_W-1:0] coef_q;
  logic signed [arx_pkg::COEF_W-1:0] coef_d;
  logic                              wr_hit;
  logic signed [PW-1:0]              sample_ext;
  logic signed [PW-1:0]              coef_ext;

  assign wr_hit = WRITABLE && cfg_i.valid
                  && (cfg_i.index == arx_pkg::CFG_IDX_W'(REG_IDX));
  assign coef_d = wr_hit ? cfg_i.data : coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign sample_ext = PW'(sample_i);
  assign coef_ext   = PW'(coef_q);
  assign prod_o     = sample_ext * coef_ext;

endmodule

[src/arx_out_stage.sv]
module arx_out_stage #(
  parameter int SW    = arx_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_W = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [ACC_W-1:0] acc_i,
  input  logic                    load_i,
  output logic                    ready_o,
  output logic signed [SW-1:0]    y_o,
  arx_out_if.source               result_o
);

  localparam int RW = ACC_W - arx_pkg::FRAC_SHIFT;

  logic signed [ACC_W-1:0] biased;
  logic signed [RW-1:0]    rounded;
  logic [RW-SW:0]          top_bits;
  logic                    ovf;
  logic                    valid_q, valid_d;
  logic signed [SW-1:0]    data_q, data_d;
  logic                    sat_q, sat_d;

  // Round half up, then drop the fraction; taking the upper bits floors.
  assign biased  = acc_i + (ACC_W'(1) <<< (arx_pkg::FRAC_SHIFT - 1));
  assign rounded = biased[ACC_W-1:arx_pkg::FRAC_SHIFT];

  // The value fits when every bit above the sample's sign bit copies it.
  assign top_bits = rounded[RW-1:SW-1];
  assign ovf      = !((&top_bits) || (~|top_bits));

  always_comb begin
    if (!ovf) begin
      y_o = rounded[SW-1:0];
    end else if (rounded[RW-1]) begin
      y_o = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y_o = {1'b0, {(SW-1){1'b1}}};
    end
  end

  assign ready_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    sat_d   = sat_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = y_o;
      sat_d   = ovf;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    sat_q  <= sat_d;
  end

  assign result_o.valid        = valid_q;
  assign result_o.model_output = data_q;
  assign result_o.saturated    = sat_q;

endmodule

[test/arx_model_step_tb.sv]
module arx_model_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = arx_pkg::SAMPLE_WIDTH_DEF;
  localparam int IN_DEPTH = arx_pkg::MAX_DELAY_DEF + arx_pkg::B_ORDER_DEF;
  localparam longint Y_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint Y_MIN = -Y_MAX - 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_PHASES = 14;
  localparam int WORDS_PER_PHASE = 100;

  // Index 7 has no register behind it; writes there must be dropped.
  localparam logic [arx_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic signed [SW-1:0] drive;
    logic signed [SW-1:0] noise;
  } arx_sample_t;

  typedef struct {
    logic signed [SW-1:0] y;
    logic                 sat;
  } arx_result_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_QUARTER, RX_SPARSE} rx_mode_e;

  logic clk_i;
  logic rst_ni;

  arx_in_if  #(.SW(SW)) drv_if ();
  arx_out_if #(.SW(SW)) res_if ();
  arx_cfg_if            cfg_if ();

  arx_model_step i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .drive_i  (drv_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // Predictor state, mirrors the block's registers and histories.
  logic signed [arx_pkg::COEF_W-1:0] fb_coef  [arx_pkg::NUM_A_REGS];
  logic signed [arx_pkg::COEF_W-1:0] fwd_coef [arx_pkg::NUM_B_REGS];
  logic [arx_pkg::DELAY_W-1:0]       delay_reg;
  logic signed [SW-1:0]              u_hist   [IN_DEPTH];
  logic signed [SW-1:0]              y_hist   [arx_pkg::A_ORDER_DEF];

  arx_sample_t pending_words[$];
  arx_result_t model_out_q[$];

  int       mismatches = 0;
  int       cycles = 0;
  logic     drv_fire = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  bit       drain_hold = 1'b0;
  int       mode_left = 0;
  rx_mode_e rx_mode = RX_OPEN;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void apply_reg(input logic [arx_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [arx_pkg::COEF_W-1:0] val);
    case (idx)
      arx_pkg::REG_A1:    fb_coef[0] = val;
      arx_pkg::REG_A2:    fb_coef[1] = val;
      arx_pkg::REG_A3:    fb_coef[2] = val;
      arx_pkg::REG_B0:    fwd_coef[0] = val;
      arx_pkg::REG_B1:    fwd_coef[1] = val;
      arx_pkg::REG_B2:    fwd_coef[2] = val;
      arx_pkg::REG_DELAY: delay_reg = val[arx_pkg::DELAY_W-1:0];
      default: ;
    endcase
  endfunction

  // Advances the predicted model by one sample and returns the expected output word.
  function automatic arx_result_t arx_step(input logic signed [SW-1:0] u,
                                           input logic signed [SW-1:0] nz);
    longint      acc;
    longint      y;
    int          k;
    arx_result_t r;
    k = (delay_reg > arx_pkg::MAX_DELAY_DEF) ? arx_pkg::MAX_DELAY_DEF : int'(delay_reg);
    for (int i = IN_DEPTH - 1; i > 0; i--) u_hist[i] = u_hist[i-1];
    u_hist[0] = u;
    acc = 0;
    for (int i = 0; i < arx_pkg::A_ORDER_DEF; i++) begin
      acc -= longint'(fb_coef[i]) * longint'(y_hist[i]);
    end
    for (int i = 0; i < arx_pkg::B_ORDER_DEF; i++) begin
      if (k + i < IN_DEPTH) acc += longint'(fwd_coef[i]) * longint'(u_hist[k+i]);
    end
    acc += longint'(nz) <<< arx_pkg::FRAC_SHIFT;
    // Round half up, then an arithmetic shift floors toward minus infinity.
    y = (acc + (longint'(1) <<< (arx_pkg::FRAC_SHIFT - 1))) >>> arx_pkg::FRAC_SHIFT;
    r.sat = 1'b0;
    if (y > Y_MAX) begin
      y = Y_MAX;
      r.sat = 1'b1;
    end else if (y < Y_MIN) begin
      y = Y_MIN;
      r.sat = 1'b1;
    end
    r.y = SW'(y);
    for (int i = arx_pkg::A_ORDER_DEF - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
    y_hist[0] = r.y;
    return r;
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SW'(Y_MAX);
      1: return SW'(Y_MIN);
      2: return SW'(int'($urandom_range(0, 512)) - 256);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [arx_pkg::COEF_W-1:0] pick_coef(input bit tame);
    if (tame) return arx_pkg::COEF_W'(int'($urandom_range(0, 8192)) - 4096);
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return arx_pkg::COEF_W'($urandom);
    endcase
  endfunction

  task automatic push_word(input logic [SW-1:0] d, input logic [SW-1:0] n);
    arx_sample_t w;
    w.drive = d;
    w.noise = n;
    pending_words = {pending_words, w};
  endtask

  // Each write holds valid across back-to-back calls; end_cfg drops it afterwards.
  task automatic write_reg(input logic [arx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [arx_pkg::COEF_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  task automatic end_cfg();
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_all_regs(input logic [arx_pkg::COEF_W-1:0] a1,
                              input logic [arx_pkg::COEF_W-1:0] a2,
                              input logic [arx_pkg::COEF_W-1:0] a3,
                              input logic [arx_pkg::COEF_W-1:0] b0,
                              input logic [arx_pkg::COEF_W-1:0] b1,
                              input logic [arx_pkg::COEF_W-1:0] b2,
                              input logic [arx_pkg::COEF_W-1:0] dly);
    write_reg(arx_pkg::REG_A1, a1);
    write_reg(arx_pkg::REG_A2, a2);
    write_reg(arx_pkg::REG_A3, a3);
    write_reg(arx_pkg::REG_B0, b0);
    write_reg(arx_pkg::REG_B1, b1);
    write_reg(arx_pkg::REG_B2, b2);
    write_reg(arx_pkg::REG_DELAY, dly);
  endtask

  // Sampled just after the rising edge so that the monitor and driver have settled.
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_words.size() != 0 || model_out_q.size() != 0 || drv_if.valid);
  endtask

  always @(negedge clk_i) begin : drive_proc
    arx_sample_t w;
    if (rst_ni && !(drv_if.valid && !drv_fire)) begin
      if (drain_hold && model_out_q.size() == 0) drain_hold = 1'b0;
      if (gap_left != 0 || drain_hold || pending_words.size() == 0) begin
        if (gap_left != 0) gap_left--;
        drv_if.valid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        drv_if.valid        <= 1'b1;
        drv_if.drive_sample <= w.drive;
        drv_if.noise_sample <= w.noise;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          // Now and then hold off until every outstanding result has come back.
          drain_hold = ($urandom_range(0, 30) == 0);
        end
      end
    end
  end

  always @(negedge clk_i) begin : ready_proc
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 200);
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
    end else begin
      mode_left--;
    end
    case (rx_mode)
      RX_OPEN:    res_if.ready <= 1'b1;
      RX_HALF:    res_if.ready <= 1'($urandom_range(0, 1));
      RX_QUARTER: res_if.ready <= (mode_left % 4 == 0);
      default:    res_if.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk_i) begin : check_proc
    arx_result_t want;
    arx_result_t pred;
    if (rst_ni) begin
      drv_fire <= drv_if.valid && drv_if.ready;
      if (res_if.valid && res_if.ready) begin
        if (model_out_q.size() == 0) begin
          $error("result word with no prediction pending: model_output %0d saturated %0b",
                 res_if.model_output, res_if.saturated);
          mismatches++;
        end else begin
          want = model_out_q.pop_front();
          if (res_if.model_output !== want.y) begin
            $error("model_output: expected %0d, got %0d", want.y, res_if.model_output);
            mismatches++;
          end
          if (res_if.saturated !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, res_if.saturated);
            mismatches++;
          end
        end
      end
      if (drv_if.valid && drv_if.ready) begin
        pred = arx_step(drv_if.drive_sample, drv_if.noise_sample);
        model_out_q = {model_out_q, pred};
      end
    end
  end

  always @(posedge clk_i) begin : watchdog_proc
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stim_proc
    bit                         tame;
    logic [arx_pkg::COEF_W-1:0] fixed_coef;
    logic [arx_pkg::COEF_W-1:0] dly;
    rst_ni              = 1'b0;
    drv_if.valid        = 1'b0;
    drv_if.drive_sample = '0;
    drv_if.noise_sample = '0;
    res_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    for (int i = 0; i < arx_pkg::NUM_A_REGS; i++) fb_coef[i] = '0;
    for (int i = 0; i < arx_pkg::NUM_B_REGS; i++) fwd_coef[i] = '0;
    for (int i = 0; i < IN_DEPTH; i++) u_hist[i] = '0;
    for (int i = 0; i < arx_pkg::A_ORDER_DEF; i++) y_hist[i] = '0;
    delay_reg = arx_pkg::DELAY_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: all coefficients zero, so the output is just the noise.
    push_word(16'h7FFF, 16'h7FFF);
    push_word(16'h8000, 16'h8000);
    push_word(16'h1234, 16'hFFFF);
    wait_drained();

    // Extreme coefficients, zero delay: strong positive feedback drives saturation.
    set_all_regs(16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h4000, 16'h0000);
    end_cfg();
    push_word(16'h7FFF, 16'h0000);
    push_word(16'h7FFF, 16'h7FFF);
    push_word(16'h8000, 16'h8000);
    push_word(16'h8000, 16'h0000);
    push_word(16'h0000, 16'h0000);
    push_word(16'hFFFF, 16'h0001);
    push_word(16'h5555, 16'hAAAA);
    push_word(16'hAAAA, 16'h5555);
    wait_drained();

    // Delay field beyond range clamps to the deepest tap; the unused index is ignored.
    set_all_regs(16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'hC000, 16'h0001, 16'hFFFF);
    write_reg(REG_NONE, 16'hFFFF);
    end_cfg();
    for (int i = 0; i < 10; i++) push_word(pick_sample(), pick_sample());
    wait_drained();

    // Random phases; the delay changes between them while the history carries over.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      tame = (ph % 4 < 2);
      if (ph % 4 == 3) begin
        fixed_coef = (ph < RAND_PHASES / 2) ? 16'h8000 : 16'h7FFF;
        dly        = (ph < RAND_PHASES / 2) ? 16'(arx_pkg::MAX_DELAY_DEF) : 16'h0000;
        set_all_regs(fixed_coef, fixed_coef, fixed_coef, fixed_coef, fixed_coef, fixed_coef,
                     dly);
      end else begin
        dly = {12'($urandom), 4'($urandom_range(0, 15))};
        set_all_regs(pick_coef(tame), pick_coef(tame), pick_coef(tame),
                     pick_coef(1'b0), pick_coef(1'b0), pick_coef(1'b0), dly);
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_NONE, 16'($urandom));
      end_cfg();
      for (int i = 0; i < WORDS_PER_PHASE; i++) push_word(pick_sample(), pick_sample());
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
